// File: hw/rtl/pipt_pkg.sv
// Shared constants and types for the point-in-polygon crossing-number test.
`default_nettype none
package pipt_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_COORD_WIDTH  = 24;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One vertex read handed from the sequencer to the edge unit.
  typedef struct packed {
    logic vld;
    logic first;
  } edge_req_t;

  // Status of the edge unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic tog;
  } edge_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/pipt_edge_unit.sv
// Pipelined edge crossing unit: one polygon edge per cycle, gives a toggle per edge.
`default_nettype none
module pipt_edge_unit #(
  parameter int COORD_WIDTH = pipt_pkg::DEF_COORD_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  pipt_pkg::edge_req_t          req,
  input  wire logic signed [COORD_WIDTH-1:0] cur_x,
  input  wire logic signed [COORD_WIDTH-1:0] cur_y,
  input  wire logic signed [COORD_WIDTH-1:0] px,
  input  wire logic signed [COORD_WIDTH-1:0] py,
  output pipt_pkg::edge_stat_t         stat
);
  import pipt_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] prev_x, prev_y;

  logic                 s1_vld, s1_str;
  logic signed [DW-1:0] s1_a, s1_b, s1_c, s1_d;

  logic                 s2_vld, s2_str, s2_dyneg;
  logic signed [PW-1:0] s2_p1, s2_p2;

  logic                 s3_vld, s3_tog;

  logic signed [PW:0]   diff;
  logic                 str_now;

  // The edge runs from the previous vertex (j) to the current one (i).
  assign str_now = (cur_y > py) != (prev_y > py);

  // Sign of (px-xi)*dy - (xj-xi)*(py-yi); a toggle needs it nonzero and opposite to dy.
  assign diff = (PW+1)'(s2_p1) - (PW+1)'(s2_p2);

  always_ff @(posedge clk) begin
    if (req.vld) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    s1_a   <= DW'(px) - DW'(cur_x);
    s1_b   <= DW'(prev_y) - DW'(cur_y);
    s1_c   <= DW'(prev_x) - DW'(cur_x);
    s1_d   <= DW'(py) - DW'(cur_y);
    s1_str <= str_now;

    s2_p1    <= s1_a * s1_b;
    s2_p2    <= s1_c * s1_d;
    s2_str   <= s1_str;
    s2_dyneg <= s1_b[DW-1];

    s3_tog <= s2_str && (diff != '0) && (diff[PW] != s2_dyneg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s1_vld <= req.vld && !req.first;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  assign stat.busy = s1_vld | s2_vld | s3_vld;
  assign stat.tog  = s3_vld & s3_tog;

endmodule
`default_nettype wire

// File: hw/rtl/point_in_polygon_test_core.sv
// Top level of the crossing-number point-in-polygon test with its vertex store.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+---------------------------
//  item in   | start, busy, kind, vertex_index, coord_x/y     | taken when start && !busy
//  result    | done, inside_res                               | one-cycle strobe on done
//  config    | cfg_valid, cfg_ready, cfg_data (vertex_count)  | written on valid && ready
//
// A load item writes the vertex store in the cycle it is taken and never raises busy.
// A query with at least three vertices walks the n stored vertices: the single read port
// of the vertex store delivers one vertex per cycle (n + 1 reads, the last vertex
// first to close the polygon), then the three-stage edge unit drains.
// A query with fewer than three vertices gives its result in the next cycle.
// Reset clears the sequencer and vertex_count; the vertex store is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result.
`default_nettype none
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pipt_pkg::DEF_MAX_VERTICES,
  parameter int COORD_WIDTH  = pipt_pkg::DEF_COORD_WIDTH
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      start,
  output logic                                     busy,
  input  wire                                      kind,
  input  wire  [$clog2(MAX_VERTICES)-1:0]          vertex_index,
  input  wire  logic signed [COORD_WIDTH-1:0]      coord_x,
  input  wire  logic signed [COORD_WIDTH-1:0]      coord_y,
  output logic                                     done,
  output logic                                     inside_res,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire  [$clog2(MAX_VERTICES+1)-1:0]        cfg_data
);
  import pipt_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int MW    = 2 * COORD_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;

  logic [MW-1:0] mem [MAX_VERTICES];
  logic [MW-1:0] rd_data;

  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] rd_cnt;
  logic [IDX_W-1:0] addr;
  logic             rd_vld, rd_first;
  logic             flag;
  logic signed [COORD_WIDTH-1:0] px, py;

  logic       take, take_load, take_query;
  edge_req_t  req;
  edge_stat_t stat;

  assign take       = start && !busy;
  assign take_load  = take && (kind == KIND_LOAD);
  assign take_query = take && (kind == KIND_QUERY);
  assign busy       = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;

  assign n_sat = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take_load && ({1'b0, vertex_index} < (IDX_W+1)'(MAX_VERTICES))) begin
      mem[vertex_index] <= {coord_x, coord_y};
    end
    if (state == ST_WALK) begin
      rd_data <= mem[addr];
    end
  end

  // The walk reads the last vertex first so that the closing edge comes out first.
  always_ff @(posedge clk) begin
    if (take_query) begin
      px    <= coord_x;
      py    <= coord_y;
      n_eff <= n_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      addr       <= '0;
      rd_cnt     <= '0;
      rd_vld     <= 1'b0;
      rd_first   <= 1'b0;
      flag       <= 1'b0;
      done       <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
      if (stat.tog) begin
        flag <= ~flag;
      end
      case (state)
        ST_IDLE: begin
          if (take_query) begin
            flag <= 1'b0;
            if (n_sat < CNT_W'(3)) begin
              done       <= 1'b1;
              inside_res <= 1'b0;
            end else begin
              addr   <= IDX_W'(n_sat - CNT_W'(1));
              rd_cnt <= '0;
              state  <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          rd_vld   <= 1'b1;
          rd_first <= (rd_cnt == '0);
          addr     <= (rd_cnt == '0) ? '0 : addr + IDX_W'(1);
          rd_cnt   <= rd_cnt + CNT_W'(1);
          if (rd_cnt == n_eff) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld && !stat.busy) begin
            done       <= 1'b1;
            inside_res <= flag;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.vld   = rd_vld;
  assign req.first = rd_first;

  pipt_edge_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cur_x(rd_data[MW-1:COORD_WIDTH]),
    .cur_y(rd_data[COORD_WIDTH-1:0]),
    .px   (px),
    .py   (py),
    .stat (stat)
  );

endmodule
`default_nettype wire

// File: hw/rtl/pipt_checker.sv
// Port-level checks on the point-in-polygon core, bound to its top level.
`default_nettype none
module pipt_checker (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire kind,
  input wire done,
  input wire inside_res
);

  // A result is only given once the walk is over.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a query is still running");

  // A load item never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && !kind) |=> !done)
    else $error("result strobe after a load item");

  // A query either starts a walk or answers at once.
  a_query_moves: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && kind) |=> (busy || done))
    else $error("query item neither started nor answered");

  // The end of every walk delivers exactly its result.
  a_walk_ends: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("walk ended without a result");

  // The result port only moves together with its strobe.
  a_res_steady: assert property (@(posedge clk) disable iff (rst)
      !$stable(inside_res) |-> done)
    else $error("inside_res changed without a result strobe");

endmodule

bind point_in_polygon_test_core pipt_checker u_pipt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .kind      (kind),
  .done      (done),
  .inside_res(inside_res)
);
`default_nettype wire
